[sv/particle_table_update_engine_macros.svh]
// Assertion helpers shared by the checking code of the engine
`ifndef PARTICLE_TABLE_UPDATE_ENGINE_MACROS_SVH
`define PARTICLE_TABLE_UPDATE_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PTUE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PTUE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ptue_pkg.sv]
package ptue_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int CNT_W  = 7;
  localparam int SLOT_W = 6;

  localparam logic signed [31:0] Q_PI_HALF = 32'sd102944;
  localparam logic signed [31:0] Q_TWO_PI  = 32'sd411775;
  localparam logic signed [16:0] LIFE_MIN  = -17'sd65536;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_CREATE = 1'b1;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] rot;
    logic signed [31:0] spin;
    logic signed [16:0] life;
    logic [7:0]         fc;
    logic [7:0]         tpf;
    logic [7:0]         cur;
    logic [7:0]         nxt;
    logic [7:0]         age;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WRD, S_WCHK, S_WLAST, S_VX, S_VY, S_PX, S_PY,
    S_ROT, S_COR, S_WR, S_ERD, S_EOUT
  } state_t;

  // start pulse and completion flag of the angle unit
  typedef struct packed {
    logic start;
    logic done;
  } cor_ctl_t;

  // arctangent of 2^-i, Q16.16, rounded to nearest
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // 32-bit signed add, clamped to the representable range
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (s < -33'sd2147483648) r = 32'sh80000000;
    else                           r = s[31:0];
    return r;
  endfunction

endpackage

[sv/ptue_cordic.sv]
module ptue_cordic #(
  parameter int STEPS = ptue_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ptue_pkg::cor_ctl_t ctl_in,
  output ptue_pkg::cor_ctl_t ctl_out,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  output logic signed [31:0] angle
);

  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic               busy;
  logic [4:0]         step;
  logic signed [34:0] x, y;
  logic signed [19:0] z;
  logic signed [34:0] dx, dy;
  logic signed [19:0] za;
  logic signed [34:0] x_n, y_n;
  logic signed [19:0] z_n;
  logic               done;

  // one vectoring iteration a cycle
  always_comb begin
    dx  = y >>> step;
    dy  = x >>> step;
    za  = 20'(signed'({1'b0, ptue_pkg::atan_q16(step)}));
    if (!y[34]) begin
      x_n = x + dx;
      y_n = y - dy;
      z_n = z + za;
    end else begin
      x_n = x - dx;
      y_n = y + dy;
      z_n = z - za;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        if (vx == 32'sd0 && vy == 32'sd0) begin
          done  <= 1'b1;
          angle <= -ptue_pkg::Q_TWO_PI;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (z_n > 20'sd0)      angle <= 32'(z_n) - ptue_pkg::Q_TWO_PI;
          else if (z_n < 20'sd0) angle <= 32'(z_n);
          else                   angle <= -ptue_pkg::Q_TWO_PI;
        end
      end
    end
  end

  // load with quadrant fold, then iterate
  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      step <= 5'd0;
      if (vx < 0) begin
        if (vy >= 0) begin
          x <= 35'(vy);
          y <= -35'(vx);
          z <= 20'(ptue_pkg::Q_PI_HALF);
        end else begin
          x <= -35'(vy);
          y <= 35'(vx);
          z <= -20'(ptue_pkg::Q_PI_HALF);
        end
      end else begin
        x <= 35'(vx);
        y <= 35'(vy);
        z <= 20'sd0;
      end
    end else if (busy) begin
      x    <= x_n;
      y    <= y_n;
      z    <= z_n;
      step <= step + 5'd1;
    end
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = done;

endmodule

[sv/particle_table_update_engine.sv]
// Channel | handshake          | payload
// input   | in_valid/in_stall  | action, pos_x .. spin_rate
// output  | out_valid/out_stall| status, live_count, slot, out_pos_x .. last
//
// A create or a full/empty answer is given straight from idle. A tick walks the live
// slots: per slot read, check, four saturating adds, the rotation
// step, write back, plus a read of the last entry when a dead entry fetches it,
// plus the angle unit's run when the rotation follows the velocity, then a read
// and a send per emitted beat.
// The shared adder and the iterative angle unit serialize these steps.
// Reset clears the count and the sequencer; the table is not cleared.
// Output stalls hold the emit pass; input is stalled whenever not idle or
// while a result beat is held.
`include "particle_table_update_engine_macros.svh"

module particle_table_update_engine #(
  parameter int MAX_PARTICLES = ptue_pkg::MAX_PARTICLES_DEF,
  parameter int CORDIC_STEPS  = ptue_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic [15:0]        lifetime,
  input  logic signed [31:0] start_angle,
  input  logic [7:0]         frame_total,
  input  logic [7:0]         ticks_per_frame,
  input  logic signed [31:0] spin_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [6:0]         live_count,
  output logic [5:0]         slot,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_angle,
  output logic [7:0]         cur_frame,
  output logic [7:0]         nxt_frame,
  output logic [7:0]         age_in_frame,
  output logic signed [16:0] life_left,
  output logic               last
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [6:0] MAXC = 7'(MAX_PARTICLES);

  ptue_pkg::state_t state, state_next;
  ptue_pkg::entry_t mem [MAX_PARTICLES];
  ptue_pkg::entry_t rdata, work, new_ent, upd;
  ptue_pkg::cor_ctl_t cor_in, cor_out;

  logic [6:0]  cnt, idx, nrep, eidx;
  logic [6:0]  last_idx;
  logic [AW-1:0] raddr;
  logic        ren, wen;
  logic [AW-1:0] waddr;
  ptue_pkg::entry_t wdata;
  logic        out_free, accept;
  logic signed [31:0] op_a, op_b, add_sat, add_wrap, cor_z;
  logic [8:0]  age9;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == ptue_pkg::S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign last_idx = cnt - 7'd1;

  // capture the new particle as stored
  always_comb begin
    new_ent.px   = pos_x;
    new_ent.py   = pos_y;
    new_ent.vx   = vel_x;
    new_ent.vy   = vel_y;
    new_ent.ax   = acc_x;
    new_ent.ay   = acc_y;
    new_ent.rot  = start_angle;
    new_ent.spin = spin_rate;
    new_ent.life = 17'(signed'({1'b0, lifetime}));
    new_ent.fc   = frame_total;
    new_ent.tpf  = ticks_per_frame;
    new_ent.cur  = 8'd0;
    new_ent.nxt  = (frame_total <= 8'd1) ? 8'd0 : 8'd1;
    new_ent.age  = 8'd0;
  end

  // shared adder: operands chosen by the sequencer step
  always_comb begin
    case (state)
      ptue_pkg::S_VX: begin op_a = work.vx;  op_b = work.ax;   end
      ptue_pkg::S_VY: begin op_a = work.vy;  op_b = work.ay;   end
      ptue_pkg::S_PX: begin op_a = work.px;  op_b = work.vx;   end
      ptue_pkg::S_PY: begin op_a = work.py;  op_b = work.vy;   end
      default:        begin op_a = work.rot; op_b = work.spin; end
    endcase
    add_sat  = ptue_pkg::sat_add(op_a, op_b);
    add_wrap = op_a + op_b;
  end

  // animation and life for write back
  always_comb begin
    upd  = work;
    age9 = {1'b0, work.age} + 9'd1;
    upd.age = age9[7:0];
    if (age9 >= {1'b0, work.tpf}) begin
      upd.age = 8'd0;
      upd.cur = work.nxt;
      if (work.fc == 8'd0 || ({1'b0, work.nxt} + 9'd1) == {1'b0, work.fc})
        upd.nxt = 8'd0;
      else
        upd.nxt = work.nxt + 8'd1;
    end
    if (work.life != ptue_pkg::LIFE_MIN) upd.life = work.life - 17'sd1;
  end

  // next state, memory port and angle unit control
  always_comb begin
    state_next   = state;
    ren          = 1'b0;
    raddr        = idx[AW-1:0];
    wen          = 1'b0;
    waddr        = idx[AW-1:0];
    wdata        = upd;
    cor_in.start = 1'b0;
    cor_in.done  = 1'b0;
    unique case (state)
      ptue_pkg::S_IDLE: begin
        if (accept && action == ptue_pkg::ACT_CREATE && cnt < MAXC) begin
          wen   = 1'b1;
          waddr = cnt[AW-1:0];
          wdata = new_ent;
        end
        if (accept && action == ptue_pkg::ACT_TICK && cnt != 7'd0)
          state_next = ptue_pkg::S_WRD;
      end
      ptue_pkg::S_WRD: begin
        ren        = 1'b1;
        state_next = ptue_pkg::S_WCHK;
      end
      ptue_pkg::S_WCHK: begin
        if (rdata.life <= 17'sd0 && idx != last_idx) begin
          ren        = 1'b1;
          raddr      = last_idx[AW-1:0];
          state_next = ptue_pkg::S_WLAST;
        end else begin
          state_next = ptue_pkg::S_VX;
        end
      end
      ptue_pkg::S_WLAST: state_next = ptue_pkg::S_VX;
      ptue_pkg::S_VX:    state_next = ptue_pkg::S_VY;
      ptue_pkg::S_VY:    state_next = ptue_pkg::S_PX;
      ptue_pkg::S_PX:    state_next = ptue_pkg::S_PY;
      ptue_pkg::S_PY:    state_next = ptue_pkg::S_ROT;
      ptue_pkg::S_ROT: begin
        if (work.rot < 0) begin
          cor_in.start = 1'b1;
          state_next   = ptue_pkg::S_COR;
        end else begin
          state_next = ptue_pkg::S_WR;
        end
      end
      ptue_pkg::S_COR: if (cor_out.done) state_next = ptue_pkg::S_WR;
      ptue_pkg::S_WR: begin
        wen = 1'b1;
        if (idx + 7'd1 < cnt) state_next = ptue_pkg::S_WRD;
        else                  state_next = ptue_pkg::S_ERD;
      end
      ptue_pkg::S_ERD: begin
        ren        = 1'b1;
        raddr      = eidx[AW-1:0];
        state_next = ptue_pkg::S_EOUT;
      end
      ptue_pkg::S_EOUT: begin
        if (out_free) begin
          if (eidx + 7'd1 == nrep) state_next = ptue_pkg::S_IDLE;
          else                     state_next = ptue_pkg::S_ERD;
        end
      end
      default: state_next = ptue_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ptue_pkg::S_IDLE;
    else     state <= state_next;
  end

  // table storage, registered read
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (ren) rdata <= mem[raddr];
  end

  ptue_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (cor_in),
    .ctl_out(cor_out),
    .vx     (work.vx),
    .vy     (work.vy),
    .angle  (cor_z)
  );

  // count, walk indices
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 7'd0;
      idx  <= 7'd0;
      eidx <= 7'd0;
      nrep <= 7'd0;
    end else begin
      if (state == ptue_pkg::S_IDLE && accept) begin
        idx  <= 7'd0;
        eidx <= 7'd0;
        if (action == ptue_pkg::ACT_CREATE && cnt < MAXC) cnt <= cnt + 7'd1;
      end
      if (state == ptue_pkg::S_WCHK && rdata.life <= 17'sd0) cnt <= cnt - 7'd1;
      if (state == ptue_pkg::S_WR) begin
        idx  <= idx + 7'd1;
        nrep <= idx + 7'd1;
      end
      if (state == ptue_pkg::S_EOUT && out_free) eidx <= eidx + 7'd1;
    end
  end

  // working copy of the particle in hand
  always_ff @(posedge clk) begin
    unique case (state)
      ptue_pkg::S_WCHK:  work <= rdata;
      ptue_pkg::S_WLAST: work <= rdata;
      ptue_pkg::S_VX:    work.vx <= add_sat;
      ptue_pkg::S_VY:    work.vy <= add_sat;
      ptue_pkg::S_PX:    work.px <= add_sat;
      ptue_pkg::S_PY:    work.py <= add_sat;
      ptue_pkg::S_ROT:   if (work.rot >= 0) work.rot <= add_wrap;
      ptue_pkg::S_COR:   if (cor_out.done) work.rot <= cor_z;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ptue_pkg::S_IDLE && accept) begin
        out_valid <= 1'b1;
        last      <= 1'b1;
        status       <= ptue_pkg::ST_OK;
        live_count   <= cnt;
        slot         <= 6'd0;
        out_pos_x    <= 32'sd0;
        out_pos_y    <= 32'sd0;
        out_angle    <= 32'sd0;
        cur_frame    <= 8'd0;
        nxt_frame    <= 8'd0;
        age_in_frame <= 8'd0;
        life_left    <= 17'sd0;
        if (action == ptue_pkg::ACT_CREATE) begin
          if (cnt >= MAXC) begin
            status <= ptue_pkg::ST_FULL;
          end else begin
            live_count   <= cnt + 7'd1;
            slot         <= cnt[5:0];
            out_pos_x    <= new_ent.px;
            out_pos_y    <= new_ent.py;
            out_angle    <= new_ent.rot;
            nxt_frame    <= new_ent.nxt;
            life_left    <= new_ent.life;
          end
        end else if (cnt == 7'd0) begin
          status <= ptue_pkg::ST_EMPTY;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (state == ptue_pkg::S_EOUT && out_free) begin
        out_valid    <= 1'b1;
        last         <= (eidx + 7'd1 == nrep);
        status       <= ptue_pkg::ST_OK;
        live_count   <= cnt;
        slot         <= eidx[5:0];
        out_pos_x    <= rdata.px;
        out_pos_y    <= rdata.py;
        out_angle    <= rdata.rot;
        cur_frame    <= rdata.cur;
        nxt_frame    <= rdata.nxt;
        age_in_frame <= rdata.age;
        life_left    <= rdata.life;
      end
    end
  end

  `PTUE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= MAXC, "particle count above table size")
  `PTUE_ASSERT_NOW(a_in_idle, !in_stall, state == ptue_pkg::S_IDLE, "input taken while busy")
  `PTUE_ASSERT_NEXT(a_cor_wait, cor_in.start, state == ptue_pkg::S_COR, "angle unit not awaited")
  `PTUE_ASSERT_NOW(a_emit_range, state == ptue_pkg::S_EOUT, eidx < nrep, "emit past walk end")

endmodule

[sim/tb_particle_table_update_engine.sv]
`timescale 1ns / 1ps

module tb_particle_table_update_engine;

  localparam int TABLE_SIZE = ptue_pkg::MAX_PARTICLES_DEF;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic        act;
    logic [31:0] px, py, vx, vy, ax, ay;
    logic [15:0] life;
    logic [31:0] ang;
    logic [7:0]  fc, tpf;
    logic [31:0] spin;
  } particle_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [5:0]  slot;
    logic [31:0] px, py, ang;
    logic [7:0]  cur, nxt, age;
    logic [16:0] life;
    logic        last;
  } particle_beat_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic action;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, start_angle, spin_rate;
  logic [15:0] lifetime;
  logic [7:0] frame_total, ticks_per_frame;
  logic [1:0] status;
  logic [6:0] live_count;
  logic [5:0] slot;
  logic signed [31:0] out_pos_x, out_pos_y, out_angle;
  logic [7:0] cur_frame, nxt_frame, age_in_frame;
  logic signed [16:0] life_left;
  logic last;

  // shadow of the particle table
  longint tab_px[TABLE_SIZE], tab_py[TABLE_SIZE], tab_vx[TABLE_SIZE], tab_vy[TABLE_SIZE];
  longint tab_ax[TABLE_SIZE], tab_ay[TABLE_SIZE], tab_rot[TABLE_SIZE], tab_spin[TABLE_SIZE];
  longint tab_life[TABLE_SIZE];
  int tab_fc[TABLE_SIZE], tab_tpf[TABLE_SIZE], tab_cur[TABLE_SIZE], tab_nxt[TABLE_SIZE];
  int tab_age[TABLE_SIZE];
  int live_particles;

  particle_beat_t expected_beats[$];
  int mismatches;
  int quiet_cycles;
  bit gaps_on;
  int in_gap_left, out_stall_left;

  particle_table_update_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .acc_x(acc_x), .acc_y(acc_y), .lifetime(lifetime), .start_angle(start_angle),
    .frame_total(frame_total), .ticks_per_frame(ticks_per_frame), .spin_rate(spin_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .live_count(live_count), .slot(slot),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_angle(out_angle),
    .cur_frame(cur_frame), .nxt_frame(nxt_frame), .age_in_frame(age_in_frame),
    .life_left(life_left), .last(last)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap32(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  // velocity heading by vectoring CORDIC, kept negative: a positive angle is shifted down by a full turn
  function automatic longint heading_angle(longint x, longint y);
    longint z, t, dx, dy;
    longint atans[17];
    atans = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
              256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (x == 0 && y == 0) return -longint'(ptue_pkg::Q_TWO_PI);
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(ptue_pkg::Q_PI_HALF);
      end else begin
        t = x; x = -y; y = t; z = -longint'(ptue_pkg::Q_PI_HALF);
      end
    end
    for (int i = 0; i < ptue_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atans[i];
      end else begin
        x -= dx; y += dy; z -= atans[i];
      end
    end
    if (z > 0) return z - longint'(ptue_pkg::Q_TWO_PI);
    if (z < 0) return z;
    return -longint'(ptue_pkg::Q_TWO_PI);
  endfunction

  function automatic particle_beat_t slot_beat(int s);
    particle_beat_t b;
    b = '0;
    b.status = ptue_pkg::ST_OK;
    b.slot = s[5:0];
    b.px = tab_px[s][31:0];
    b.py = tab_py[s][31:0];
    b.ang = tab_rot[s][31:0];
    b.cur = tab_cur[s][7:0];
    b.nxt = tab_nxt[s][7:0];
    b.age = tab_age[s][7:0];
    b.life = tab_life[s][16:0];
    return b;
  endfunction

  task automatic move_particle(int s);
    tab_vx[s] = clamp32(tab_vx[s] + tab_ax[s]);
    tab_vy[s] = clamp32(tab_vy[s] + tab_ay[s]);
    tab_px[s] = clamp32(tab_px[s] + tab_vx[s]);
    tab_py[s] = clamp32(tab_py[s] + tab_vy[s]);
    if (tab_rot[s] < 0) tab_rot[s] = heading_angle(tab_vx[s], tab_vy[s]);
    else tab_rot[s] = wrap32(tab_rot[s] + tab_spin[s]);
    tab_age[s] = (tab_age[s] + 1) & 'h1FF;
    if (tab_age[s] >= tab_tpf[s]) begin
      tab_age[s] = 0;
      tab_cur[s] = tab_nxt[s] & 'hFF;
      tab_nxt[s] = (tab_fc[s] != 0) ? ((tab_cur[s] + 1) % tab_fc[s]) & 'hFF : 0;
    end
    if (tab_life[s] > -65536) tab_life[s] -= 1;
  endtask

  // work out the beats that one accepted item causes
  task automatic predict_step(particle_req_t r);
    particle_beat_t b;
    particle_beat_t pass_beats[$];
    int s;
    if (r.act == ptue_pkg::ACT_CREATE) begin
      b = '0;
      if (live_particles >= TABLE_SIZE) begin
        b.status = ptue_pkg::ST_FULL;
      end else begin
        s = live_particles;
        tab_px[s] = longint'($signed(r.px)); tab_py[s] = longint'($signed(r.py));
        tab_vx[s] = longint'($signed(r.vx)); tab_vy[s] = longint'($signed(r.vy));
        tab_ax[s] = longint'($signed(r.ax)); tab_ay[s] = longint'($signed(r.ay));
        tab_life[s] = longint'(r.life);
        tab_rot[s] = longint'($signed(r.ang)); tab_spin[s] = longint'($signed(r.spin));
        tab_fc[s] = r.fc; tab_tpf[s] = r.tpf;
        tab_cur[s] = 0; tab_nxt[s] = (r.fc <= 1) ? 0 : 1; tab_age[s] = 0;
        live_particles = s + 1;
        b = slot_beat(s);
      end
      b.count = live_particles[6:0];
      b.last = 1'b1;
      expected_beats.push_back(b);
      return;
    end
    if (live_particles == 0) begin
      b = '0;
      b.status = ptue_pkg::ST_EMPTY;
      b.last = 1'b1;
      expected_beats.push_back(b);
      return;
    end
    for (int i = 0; i < live_particles; i++) begin
      // replace a dead entry by the last one before updating the slot
      if (tab_life[i] <= 0) begin
        s = live_particles - 1;
        if (s != i) begin
          tab_px[i] = tab_px[s]; tab_py[i] = tab_py[s];
          tab_vx[i] = tab_vx[s]; tab_vy[i] = tab_vy[s];
          tab_ax[i] = tab_ax[s]; tab_ay[i] = tab_ay[s];
          tab_rot[i] = tab_rot[s]; tab_spin[i] = tab_spin[s];
          tab_fc[i] = tab_fc[s]; tab_tpf[i] = tab_tpf[s];
          tab_cur[i] = tab_cur[s]; tab_nxt[i] = tab_nxt[s]; tab_age[i] = tab_age[s];
          tab_life[i] = tab_life[s];
        end
        live_particles = s;
      end
      move_particle(i);
      pass_beats.push_back(slot_beat(i));
    end
    foreach (pass_beats[k]) begin
      pass_beats[k].count = live_particles[6:0];
      pass_beats[k].last = (k == pass_beats.size() - 1);
      expected_beats.push_back(pass_beats[k]);
    end
  endtask

  // drive one beat at the falling edge and hold it until taken
  task automatic send_item(particle_req_t r);
    if (gaps_on && in_gap_left == 0 && $urandom_range(0, 5) == 0)
      in_gap_left = $urandom_range(1, 16);
    if (in_gap_left > 0) begin
      in_valid = 1'b0;
      repeat (in_gap_left) @(negedge clk);
      in_gap_left = 0;
    end
    action = r.act; pos_x = r.px; pos_y = r.py; vel_x = r.vx; vel_y = r.vy;
    acc_x = r.ax; acc_y = r.ay; lifetime = r.life; start_angle = r.ang;
    frame_total = r.fc; ticks_per_frame = r.tpf; spin_rate = r.spin;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_step(r);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 'h80000)) - 'sh40000);
      3: return 32'($signed($urandom_range(0, 'h800)) - 'sh400);
      default: return $urandom();
    endcase
  endfunction

  function automatic particle_req_t random_create();
    particle_req_t r;
    r.act = ptue_pkg::ACT_CREATE;
    r.px = pick32(); r.py = pick32(); r.vx = pick32(); r.vy = pick32();
    r.ax = pick32(); r.ay = pick32(); r.spin = pick32();
    r.ang = $urandom_range(0, 1) ? pick32() : 32'($signed($urandom_range(0, 'h60000)) - 'sh30000);
    r.life = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
    r.fc = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
    r.tpf = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic particle_req_t tick_req();
    particle_req_t r;
    r = random_create();
    r.act = ptue_pkg::ACT_TICK;
    return r;
  endfunction

  task automatic test_empty_tick();
    send_item(tick_req());
  endtask

  // extremes of every field, the velocity-following rotation and the frame cases
  task automatic test_directed_fields();
    particle_req_t r;
    r = random_create();
    r.px = 32'h7FFFFFFF; r.py = 32'h80000000; r.vx = 32'h7FFFFFFF; r.vy = 32'h80000000;
    r.ax = 32'h7FFFFFFF; r.ay = 32'h80000000; r.life = 16'hFFFF; r.ang = 32'h7FFFFFF0;
    r.spin = 32'h7FFFFFFF; r.fc = 8'hFF; r.tpf = 8'hFF;
    send_item(r);
    r.px = 32'h80000000; r.py = 32'h7FFFFFFF; r.vx = 32'h80000000; r.vy = 32'h7FFFFFFF;
    r.ax = 32'h80000000; r.ay = 32'h7FFFFFFF; r.life = 16'd3; r.ang = 32'hFFFFFFFF;
    r.spin = 32'h80000000; r.fc = 8'd1; r.tpf = 8'd0;
    send_item(r);
    // still particle aligned with its velocity
    r.px = 0; r.py = 0; r.vx = 0; r.vy = 0; r.ax = 0; r.ay = 0;
    r.life = 16'd0; r.ang = 32'h80000000; r.spin = 0; r.fc = 8'd0; r.tpf = 8'd0;
    send_item(r);
    r.vx = 32'hFFFF0000; r.vy = 32'h00010000; r.life = 16'd2; r.fc = 8'd3; r.tpf = 8'd1;
    send_item(r);
    r.vx = 32'hFFFF0000; r.vy = 32'hFFFF0000; r.life = 16'd1; r.fc = 8'd2; r.tpf = 8'd2;
    send_item(r);
    r.vx = 32'h00010000; r.vy = 32'h0; r.life = 16'd0; r.ang = 32'hFFFF0000;
    send_item(r);
    repeat (6) send_item(tick_req());
  endtask

  // fill the table, create once more on a full table, then tick it
  task automatic test_table_full();
    particle_req_t r;
    while (live_particles < TABLE_SIZE) begin
      r = random_create();
      r.life = 16'($urandom_range(3, 40));
      send_item(r);
    end
    send_item(random_create());
    repeat (3) send_item(tick_req());
  endtask

  task automatic test_random_mix(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (live_particles < 8 || $urandom_range(0, 9) < 6) send_item(random_create());
      else send_item(tick_req());
    end
  endtask

  // output stall bursts at the falling edge
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each taken result beat with the oldest expected one
  always @(posedge clk) begin
    particle_beat_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, live_count, slot, out_pos_x, out_pos_y, out_angle,
              cur_frame, nxt_frame, age_in_frame, life_left, last};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1; in_valid = 1'b0; out_stall = 1'b0;
    action = ptue_pkg::ACT_TICK; pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
    acc_x = 0; acc_y = 0;
    lifetime = 0; start_angle = 0; frame_total = 0; ticks_per_frame = 0; spin_rate = 0;
    live_particles = 0; mismatches = 0; quiet_cycles = 0;
    in_gap_left = 0; out_stall_left = 0; gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_tick();
    test_directed_fields();
    test_table_full();
    test_random_mix(180);
    gaps_on = 1'b0;
    test_random_mix(60);
    in_valid = 1'b0;
    wait (expected_beats.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ptue_pkg.sv
sv/ptue_cordic.sv
sv/particle_table_update_engine.sv
sim/tb_particle_table_update_engine.sv
